FILE: hdl/qds_pkg.sv
package qds_pkg;

   localparam int unsigned CountWidth = 8;
   localparam int unsigned ScaleWidth = 12;

   localparam int CountLimit = 127;
   localparam int FullScale  = 2047;

   // The scale factor is split into a whole part and a remainder part, so that
   // only the remainder product needs a division by the limit.
   localparam int ScaleWhole = FullScale / CountLimit;
   localparam int ScaleRem   = FullScale % CountLimit;

   localparam logic signed [CountWidth-1:0] CountMax = CountWidth'(CountLimit);
   localparam logic signed [CountWidth-1:0] CountMin = CountWidth'(-CountLimit);

   typedef logic signed [CountWidth-1:0] count_type;
   typedef logic signed [ScaleWidth-1:0] scaled_type;

   // Tracker states: one idle/error state and four phase states.
   localparam logic [2:0] PhaseIdle = 3'd0;
   localparam logic [2:0] Phase00   = 3'd1;
   localparam logic [2:0] Phase10   = 3'd2;
   localparam logic [2:0] Phase11   = 3'd3;
   localparam logic [2:0] Phase01   = 3'd4;

endpackage

FILE: hdl/qds_req_if.sv
interface qds_req_if
   import qds_pkg::*;
   ();
   logic valid;
   logic ready;
   logic chan_a;
   logic chan_b;

   modport source (output valid, output chan_a, output chan_b, input ready);
   modport sink   (input valid, input chan_a, input chan_b, output ready);
endinterface

FILE: hdl/qds_rsp_if.sv
interface qds_rsp_if
   import qds_pkg::*;
   ();
   logic       valid;
   logic       ready;
   count_type  position;
   scaled_type scaled_position;
   logic       at_max;
   logic       at_min;

   modport source (output valid, output position, output scaled_position,
                   output at_max, output at_min, input ready);
   modport sink   (input valid, input position, input scaled_position,
                   input at_max, input at_min, output ready);
endinterface

FILE: hdl/quadrature_decoder_saturating.sv
// Quadrature decoder (x4) with a saturating signed position count. Each request
// beat carries one filtered sample of channels A and B; each one produces exactly
// one response beat with the count after that sample, the count scaled to full
// scale (truncated toward zero and clamped), and at-limit flags. The block takes
// one beat per clock while the response side keeps up: the tracker and count
// update in the accepting cycle, and the scaling happens in a second stage, so a
// response passes through the stage-one and response registers after its request
// beat. Writing csr_wdata with csr_we loads the count (clamped to the limit)
// and returns the tracker to its idle/error state; write it only while idle.
module quadrature_decoder_saturating
   import qds_pkg::*;
   (
   input  logic            clock,
   input  logic            reset,
   qds_req_if.sink         req_bus,
   qds_rsp_if.source       rsp_bus,
   input  logic            csr_we,
   input  count_type       csr_wdata
   );

   logic [2:0] phase_ff, phase_in;
   count_type  count_ff, count_in;
   logic       s1_valid_ff;
   count_type  s1_count_ff;
   logic       rsp_valid_ff;
   count_type  rsp_position_ff;
   scaled_type rsp_scaled_ff;
   logic       rsp_max_ff;
   logic       rsp_min_ff;

   logic       out_open;
   logic       s1_open;
   logic       accept;
   logic [2:0] target;
   logic [2:0] fwd;
   logic [2:0] rev;
   logic       step_up;
   logic       step_down;
   count_type  load_value;

   logic                  neg;
   logic [CountWidth-1:0] mag;
   logic [12:0]           whole_part;
   logic [11:0]           rem_prod;
   logic [4:0]            rem_quot;
   logic [11:0]           rem_left;
   logic [12:0]           mag_scaled;
   logic [ScaleWidth-1:0] mag_clamped;
   scaled_type            scaled;

   assign out_open = !rsp_valid_ff || rsp_bus.ready;
   assign s1_open  = !s1_valid_ff || out_open;
   assign accept   = req_bus.valid && s1_open;
   assign req_bus.ready = s1_open;

   always_comb begin
      case ({req_bus.chan_a, req_bus.chan_b})
         2'b00:   target = Phase00;
         2'b10:   target = Phase10;
         2'b11:   target = Phase11;
         default: target = Phase01;
      endcase
      fwd = (phase_ff == Phase01) ? Phase00 : phase_ff + 3'd1;
      rev = (phase_ff == Phase00) ? Phase01 : phase_ff - 3'd1;
   end

   always_comb begin
      step_up   = 1'b0;
      step_down = 1'b0;
      phase_in  = PhaseIdle;
      case (phase_ff)
         PhaseIdle: begin
            phase_in  = target;
            step_up   = (target == Phase00);
            step_down = (target == Phase01);
         end
         Phase00, Phase10, Phase11, Phase01: begin
            if (target == phase_ff) begin
               phase_in = phase_ff;
            end else if (target == fwd) begin
               phase_in = target;
               step_up  = 1'b1;
            end else if (target == rev) begin
               phase_in  = target;
               step_down = 1'b1;
            end else begin
               phase_in = PhaseIdle;
            end
         end
         default: phase_in = PhaseIdle;
      endcase

      count_in = count_ff;
      if (step_up && count_ff < CountMax) begin
         count_in = count_ff + count_type'(1);
      end else if (step_down && count_ff > CountMin) begin
         count_in = count_ff - count_type'(1);
      end
   end

   always_comb begin
      if (csr_wdata > CountMax) begin
         load_value = CountMax;
      end else if (csr_wdata < CountMin) begin
         load_value = CountMin;
      end else begin
         load_value = csr_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PhaseIdle;
         count_ff <= '0;
      end else if (csr_we) begin
         phase_ff <= PhaseIdle;
         count_ff <= load_value;
      end else if (accept) begin
         phase_ff <= phase_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (s1_open) begin
         s1_valid_ff <= req_bus.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_count_ff <= count_in;
      end
   end

   // Scaling: |count| * FullScale / CountLimit = ScaleWhole*m + (ScaleRem*m)/CountLimit.
   // The remainder quotient is first estimated by a shift and then corrected once.
   always_comb begin
      neg         = s1_count_ff[CountWidth-1];
      mag         = neg ? CountWidth'(-s1_count_ff) : CountWidth'(s1_count_ff);
      whole_part  = 13'(mag) * 13'(ScaleWhole);
      rem_prod    = 12'(mag) * 12'(ScaleRem);
      rem_quot    = rem_prod[11:7];
      rem_left    = rem_prod - ((12'(rem_quot) << 7) - 12'(rem_quot));
      mag_scaled  = whole_part + 13'(rem_quot)
                  + ((rem_left >= 12'(CountLimit)) ? 13'd1 : 13'd0);
      mag_clamped = (mag_scaled > 13'(FullScale)) ? ScaleWidth'(FullScale)
                                                   : mag_scaled[ScaleWidth-1:0];
      scaled      = neg ? scaled_type'(-mag_clamped) : scaled_type'(mag_clamped);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_open) begin
         rsp_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (out_open && s1_valid_ff) begin
         rsp_position_ff <= s1_count_ff;
         rsp_scaled_ff   <= scaled;
         rsp_max_ff      <= (s1_count_ff == CountMax);
         rsp_min_ff      <= (s1_count_ff == CountMin);
      end
   end

   assign rsp_bus.valid           = rsp_valid_ff;
   assign rsp_bus.position        = rsp_position_ff;
   assign rsp_bus.scaled_position = rsp_scaled_ff;
   assign rsp_bus.at_max          = rsp_max_ff;
   assign rsp_bus.at_min          = rsp_min_ff;

endmodule
